FILE: hdl/wsd_pkg.sv
// Shared types, constants, filter taps and rounding for the wavelet decomposition block.
package wsd_pkg;

	localparam int WSD_MAX_DIM = 256;
	localparam int TAPS        = 41;
	localparam int HALF_TAPS   = (TAPS - 1) / 2;
	localparam int TIW         = $clog2(TAPS);

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_LEVELS = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        pixel_index;
		logic signed [31:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               status;
	} out_item_t;

	typedef struct packed {
		logic           valid;
		logic           first;
		logic           last;
		logic           col;
		logic [TIW-1:0] tap;
	} mac_ctl_t;

	localparam logic signed [17:0] LOW_TAPS [0:TAPS-1] = '{
		18'sd0, -18'sd21, -18'sd26, 18'sd43, 18'sd52, -18'sd86, -18'sd102, 18'sd174,
		18'sd203, -18'sd360, -18'sd404, 18'sd760, 18'sd805, -18'sd1667, -18'sd1592,
		18'sd3899, 18'sd2973, -18'sd10198, -18'sd4653, 18'sd40217, 18'sd71006,
		18'sd40217, -18'sd4653, -18'sd10198, 18'sd2973, 18'sd3899, -18'sd1592,
		-18'sd1667, 18'sd805, 18'sd760, -18'sd404, -18'sd360, 18'sd203, 18'sd174,
		-18'sd102, -18'sd86, 18'sd52, 18'sd43, -18'sd26, -18'sd21, 18'sd0
	};

	localparam logic signed [17:0] HIGH_TAPS [0:TAPS-1] = '{
		18'sd0, 18'sd0, 18'sd21, -18'sd26, -18'sd43, 18'sd52, 18'sd86, -18'sd102,
		-18'sd174, 18'sd203, 18'sd360, -18'sd404, -18'sd760, 18'sd805, 18'sd1667,
		-18'sd1592, -18'sd3899, 18'sd2973, 18'sd10198, -18'sd4653, -18'sd40217,
		18'sd71006, -18'sd40217, -18'sd4653, 18'sd10198, 18'sd2973, -18'sd3899,
		-18'sd1592, 18'sd1667, 18'sd805, -18'sd760, -18'sd404, 18'sd360, 18'sd203,
		-18'sd174, -18'sd102, 18'sd86, 18'sd52, -18'sd43, -18'sd26, 18'sd21
	};

	function automatic logic signed [17:0] low_tap(input logic [TIW-1:0] t);
		if (int'(t) < TAPS) return LOW_TAPS[t];
		return 18'sd0;
	endfunction

	function automatic logic signed [17:0] high_tap(input logic [TIW-1:0] t);
		if (int'(t) < TAPS) return HIGH_TAPS[t];
		return 18'sd0;
	endfunction

	// Round half up after a shift of 16 (column) or 17 (row), then saturate.
	function automatic logic signed [31:0] round_sat(input logic signed [63:0] acc,
		input logic col);
		logic signed [63:0] t;
		logic signed [63:0] r;
		t = col ? (acc + 64'sd32768) : (acc + 64'sd65536);
		r = col ? (t >>> 16) : (t >>> 17);
		if (r > 64'sd2147483647) return 32'sh7fffffff;
		if (r < -64'sd2147483648) return 32'sh80000000;
		return r[31:0];
	endfunction

endpackage

FILE: hdl/wsd_mac.sv
// Dual multiply-accumulate for the low-pass and high-pass filter windows.
module wsd_mac
	import wsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  mac_ctl_t           ctl,
	input  logic signed [31:0] sample,
	output logic               done,
	output logic signed [31:0] lo_val,
	output logic signed [31:0] hi_val
);

	mac_ctl_t           ctl_s2;
	logic signed [49:0] prod_lo_s2;
	logic signed [49:0] prod_hi_s2;
	logic signed [63:0] acc_lo_q;
	logic signed [63:0] acc_hi_q;
	logic               col_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_lo_s2 <= sample * low_tap(ctl.tap);
		prod_hi_s2 <= sample * high_tap(ctl.tap);
		if (ctl_s2.valid) begin
			col_q <= ctl_s2.col;
			// restart the sums on the first tap of a window
			if (ctl_s2.first) begin
				acc_lo_q <= 64'(prod_lo_s2);
				acc_hi_q <= 64'(prod_hi_s2);
			end else begin
				acc_lo_q <= acc_lo_q + 64'(prod_lo_s2);
				acc_hi_q <= acc_hi_q + 64'(prod_hi_s2);
			end
		end
	end

	assign done   = done_q;
	assign lo_val = round_sat(acc_lo_q, col_q);
	assign hi_val = round_sat(acc_hi_q, col_q);

endmodule

FILE: hdl/wavelet_spline_decompose_2d.sv
// Top level of the in-place 2-D cubic-spline wavelet decomposition block.
// Pixel writes and coefficient reads are taken one per cycle while the result path is not
// stalled, and stream back to back from the image memory; a read result passes the result
// stage and then the output register. A start transaction holds stall high for the whole
// transform walk: for every line of n samples in a pass (rows first, then columns, at each
// level) the walk sets up the line and copies it into the line buffer, then for each of the
// n/2 output pairs it sets up the edge-clipped 41-tap window, runs its taps one per cycle,
// waits for the multiply-accumulate pipe to drain and writes the pair back through the
// single memory write port. Lines too short to filter are skipped, and a finish state hands
// the memory back after the last level. The image memory is not cleared after reset.
module wavelet_spline_decompose_2d
	import wsd_pkg::*;
#(
	parameter int MAX_DIM = WSD_MAX_DIM
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int MW = $clog2(MAX_DIM);
	localparam int AW = $clog2(MAX_DIM * MAX_DIM);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LVL, ST_LINE, ST_LOAD, ST_LWAIT, ST_KSET, ST_FILT, ST_DRAIN,
		ST_WRL, ST_WRH, ST_FIN
	} state_t;

	state_t state_q;

	logic [8:0] width_q;
	logic [8:0] height_q;
	logic [3:0] levels_q;

	logic signed [31:0] img_mem [0:MAX_DIM*MAX_DIM-1];
	logic signed [31:0] lb_mem  [0:MAX_DIM-1];
	logic signed [31:0] img_rdata_q;
	logic signed [31:0] lb_rdata_q;

	logic               img_we;
	logic [AW-1:0]      img_waddr;
	logic signed [31:0] img_wdata;
	logic               img_re;
	logic [AW-1:0]      img_raddr;

	logic [DW-1:0] w_dim;
	logic [DW-1:0] h_dim;
	logic [2*DW-1:0] limit;
	logic          in_range;
	logic          accept;
	logic          adv;

	logic          s1_valid_q;
	logic          s1_read_q;
	logic          s1_status_q;
	logic          out_valid_q;
	out_item_t     out_q;

	// transform walk registers
	logic [3:0]    lv_q;
	logic [DW-1:0] ix_q;
	logic [DW-1:0] iy_q;
	logic          col_pass_q;
	logic [DW-1:0] i_q;
	logic [DW-1:0] j_q;
	logic [AW-1:0] line_base_q;
	logic [DW-1:0] n_q;
	logic [MW-1:0] half_q;
	logic [AW-1:0] stride_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] lo_ptr_q;
	logic [AW-1:0] hi_ptr_q;
	logic [MW-1:0] m_q;
	logic [MW-1:0] k_q;
	logic [MW-1:0] hi_q;
	logic [TIW-1:0] t_q;
	logic          ld_valid_s1;
	logic [MW-1:0] ld_idx_s1;
	mac_ctl_t      ctl_s1;

	logic [MW-1:0]  win_lo;
	logic [MW-1:0]  win_hi;
	logic [TIW-1:0] win_t0;

	logic               mac_done;
	logic signed [31:0] mac_lo;
	logic signed [31:0] mac_hi;

	function automatic logic [DW-1:0] clamp_dim(input logic [8:0] v);
		if (v == 9'd0) return DW'(1);
		if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
		return DW'(v);
	endfunction

	assign w_dim    = clamp_dim(width_q);
	assign h_dim    = clamp_dim(height_q);
	assign limit    = (2*DW)'(w_dim) * (2*DW)'(h_dim);
	assign in_range = 32'(in_item.pixel_index) < 32'(limit);
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (s1_valid_q && !adv);
	assign accept   = in_valid && !in_stall;

	// clipped filter window around the even center 2k
	always_comb begin
		int c;
		int lo;
		int hi;
		c  = 2 * int'(k_q);
		lo = (c >= HALF_TAPS) ? c - HALF_TAPS : 0;
		hi = (c + HALF_TAPS > int'(n_q) - 1) ? int'(n_q) - 1 : c + HALF_TAPS;
		win_lo = MW'(lo);
		win_hi = MW'(hi);
		win_t0 = TIW'(HALF_TAPS + lo - c);
	end

	always_comb begin
		img_we    = 1'b0;
		img_waddr = AW'(in_item.pixel_index);
		img_wdata = in_item.pixel_value;
		img_re    = 1'b0;
		img_raddr = AW'(in_item.pixel_index);
		unique case (state_q)
			ST_IDLE: begin
				img_we = accept && (in_item.action == ACT_WRITE) && in_range;
				img_re = accept && (in_item.action == ACT_READ) && in_range;
			end
			ST_LOAD: begin
				img_re    = 1'b1;
				img_raddr = ptr_q;
			end
			ST_WRL: begin
				img_we    = 1'b1;
				img_waddr = lo_ptr_q;
				img_wdata = mac_lo;
			end
			ST_WRH: begin
				img_we    = 1'b1;
				img_waddr = hi_ptr_q;
				img_wdata = mac_hi;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (img_we) img_mem[img_waddr] <= img_wdata;
		if (img_re) img_rdata_q <= img_mem[img_raddr];
		if (ld_valid_s1) lb_mem[ld_idx_s1] <= img_rdata_q;
		if (state_q == ST_FILT) lb_rdata_q <= lb_mem[m_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			levels_q <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_LEVELS: levels_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// result path: one stage behind the memory read, then the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) out_valid_q <= s1_valid_q;
			if (accept) begin
				s1_valid_q <= (in_item.action != ACT_START);
			end else if (state_q == ST_FIN) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.read_value <= s1_read_q ? img_rdata_q : 32'sd0;
			out_q.status     <= s1_status_q;
		end
		if (accept) begin
			s1_read_q   <= (in_item.action == ACT_READ) && in_range;
			s1_status_q <= ((in_item.action == ACT_WRITE) || (in_item.action == ACT_READ))
				&& !in_range;
		end else if (state_q == ST_FIN) begin
			s1_read_q   <= 1'b0;
			s1_status_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// transform sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ld_valid_s1 <= 1'b0;
			ctl_s1      <= '0;
		end else begin
			ld_valid_s1  <= (state_q == ST_LOAD);
			ctl_s1.valid <= (state_q == ST_FILT);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_item.action == ACT_START)) begin
						lv_q    <= 4'd0;
						state_q <= ST_LVL;
					end
				end
				ST_LVL: begin
					if (lv_q == levels_q) begin
						state_q <= ST_FIN;
					end else begin
						ix_q        <= w_dim >> lv_q;
						iy_q        <= h_dim >> lv_q;
						col_pass_q  <= 1'b0;
						i_q         <= '0;
						j_q         <= '0;
						line_base_q <= '0;
						state_q     <= ST_LINE;
					end
				end
				ST_LINE: begin
					if (!col_pass_q) begin
						if (i_q == iy_q) begin
							col_pass_q <= 1'b1;
						end else if (ix_q < DW'(2)) begin
							i_q         <= i_q + DW'(1);
							line_base_q <= line_base_q + AW'(w_dim);
						end else begin
							n_q      <= ix_q;
							half_q   <= MW'(ix_q >> 1);
							stride_q <= AW'(1);
							ptr_q    <= line_base_q;
							lo_ptr_q <= line_base_q;
							m_q      <= '0;
							state_q  <= ST_LOAD;
						end
					end else begin
						if (j_q == ix_q) begin
							lv_q    <= lv_q + 4'd1;
							state_q <= ST_LVL;
						end else if (iy_q < DW'(2)) begin
							j_q <= j_q + DW'(1);
						end else begin
							n_q      <= iy_q;
							half_q   <= MW'(iy_q >> 1);
							stride_q <= AW'(w_dim);
							ptr_q    <= AW'(j_q);
							lo_ptr_q <= AW'(j_q);
							m_q      <= '0;
							state_q  <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					ld_idx_s1 <= m_q;
					if (m_q == half_q) hi_ptr_q <= ptr_q;
					ptr_q <= ptr_q + stride_q;
					m_q   <= m_q + MW'(1);
					if (DW'(m_q) == n_q - DW'(1)) state_q <= ST_LWAIT;
				end
				ST_LWAIT: begin
					// let the last sample land in the line buffer
					k_q     <= '0;
					state_q <= ST_KSET;
				end
				ST_KSET: begin
					m_q     <= win_lo;
					hi_q    <= win_hi;
					t_q     <= win_t0;
					state_q <= ST_FILT;
				end
				ST_FILT: begin
					ctl_s1.first <= (t_q == win_t0);
					ctl_s1.last  <= (m_q == hi_q);
					ctl_s1.col   <= col_pass_q;
					ctl_s1.tap   <= t_q;
					m_q <= m_q + MW'(1);
					t_q <= t_q + TIW'(1);
					if (m_q == hi_q) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (mac_done) state_q <= ST_WRL;
				end
				ST_WRL: begin
					state_q <= ST_WRH;
				end
				ST_WRH: begin
					lo_ptr_q <= lo_ptr_q + stride_q;
					hi_ptr_q <= hi_ptr_q + stride_q;
					k_q      <= k_q + MW'(1);
					if (k_q == half_q - MW'(1)) begin
						if (!col_pass_q) begin
							i_q         <= i_q + DW'(1);
							line_base_q <= line_base_q + AW'(w_dim);
						end else begin
							j_q <= j_q + DW'(1);
						end
						state_q <= ST_LINE;
					end else begin
						state_q <= ST_KSET;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	wsd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.sample (lb_rdata_q),
		.done   (mac_done),
		.lo_val (mac_lo),
		.hi_val (mac_hi)
	);

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_DRAIN))
		else $error("filter sum finished outside the drain wait");

	a_lb_fill_window: assert property (@(posedge clk) disable iff (!arst_n)
		ld_valid_s1 |-> (state_q == ST_LOAD || state_q == ST_LWAIT))
		else $error("line buffer written while the window is being read");

	a_no_result_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s1_valid_q)
		else $error("result stage occupied while the transform owns the memory");

	a_start_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.action == ACT_START) |=> (state_q == ST_LVL))
		else $error("start transaction did not launch the transform");

endmodule

FILE: sim/wavelet_spline_decompose_2d_test.sv
// Self-checking testbench for the 2-D cubic-spline wavelet decomposition block.
module wavelet_spline_decompose_2d_test;
	import wsd_pkg::*;

	localparam int IDLE_LIMIT = 200000;
	localparam int NPHASE     = 8;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        pixel_index;
		logic signed [31:0] pixel_value;
		logic               typed;
		logic signed [31:0] typed_value;
		logic               typed_status;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_write;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	// typed expectation travelling with the current input transaction
	logic               row_typed;
	logic signed [31:0] row_value;
	logic               row_status;

	logic signed [31:0] pixel_mem [0:65535];
	logic signed [31:0] line_buf [0:255];
	logic [8:0]         model_width;
	logic [8:0]         model_height;
	logic [3:0]         model_levels;
	out_item_t          coeff_queue [$];
	int                 fail_count;
	int                 idle_cycles;
	int                 send_idle_pct;
	int                 recv_stall_pct;

	wavelet_spline_decompose_2d u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int clamp_dim(input logic [8:0] v);
		if (v == 0) return 1;
		if (v > 256) return 256;
		return int'(v);
	endfunction

	function automatic logic signed [31:0] shift_round_sat(input logic signed [63:0] acc,
		input int sh);
		logic signed [63:0] t;
		t = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
		if (t > 64'sd2147483647) return 32'sh7fffffff;
		if (t < -64'sd2147483648) return 32'sh80000000;
		return t[31:0];
	endfunction

	// Filter n buffered samples; low half to the front, high half after it.
	task automatic filter_pass(input int n, input int base, input int stride, input int sh);
		int half;
		int c;
		int lo;
		int hi;
		logic signed [63:0] acc_lo;
		logic signed [63:0] acc_hi;
		half = n / 2;
		for (int k = 0; k < half; k++) begin
			c = 2 * k;
			lo = (c - HALF_TAPS < 0) ? 0 : c - HALF_TAPS;
			hi = (c + HALF_TAPS > n - 1) ? n - 1 : c + HALF_TAPS;
			acc_lo = 0;
			acc_hi = 0;
			for (int m = lo; m <= hi; m++) begin
				acc_lo += 64'(line_buf[m]) * 64'(LOW_TAPS[HALF_TAPS + m - c]);
				acc_hi += 64'(line_buf[m]) * 64'(HIGH_TAPS[HALF_TAPS + m - c]);
			end
			pixel_mem[base + k * stride] = shift_round_sat(acc_lo, sh);
			pixel_mem[base + (half + k) * stride] = shift_round_sat(acc_hi, sh);
		end
	endtask

	task automatic decompose_image();
		int w;
		int h;
		int ix;
		int iy;
		w = clamp_dim(model_width);
		h = clamp_dim(model_height);
		for (int lv = 0; lv < int'(model_levels); lv++) begin
			ix = w >> lv;
			iy = h >> lv;
			for (int i = 0; i < iy; i++) begin
				for (int j = 0; j < ix; j++) line_buf[j] = pixel_mem[i * w + j];
				filter_pass(ix, i * w, 1, 17);
			end
			for (int j = 0; j < ix; j++) begin
				for (int i = 0; i < iy; i++) line_buf[i] = pixel_mem[i * w + j];
				filter_pass(iy, j, w, 16);
			end
		end
	endtask

	task automatic predict_coeff(input in_item_t it, output out_item_t res);
		int limit;
		limit = clamp_dim(model_width) * clamp_dim(model_height);
		res = '0;
		case (it.action)
			ACT_WRITE: begin
				if (int'(it.pixel_index) < limit) pixel_mem[it.pixel_index] = it.pixel_value;
				else res.status = 1'b1;
			end
			ACT_START: decompose_image();
			ACT_READ: begin
				if (int'(it.pixel_index) < limit) res.read_value = pixel_mem[it.pixel_index];
				else res.status = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Check results first, then log the accepted input transaction.
	always @(posedge clk) begin
		out_item_t want;
		out_item_t pred;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (coeff_queue.size() == 0) begin
					report_mismatch("unexpected result", out_item.read_value, 0);
				end else begin
					want = coeff_queue.pop_front();
					if (out_item.read_value !== want.read_value)
						report_mismatch("read_value", out_item.read_value, want.read_value);
					if (out_item.status !== want.status)
						report_mismatch("status", out_item.status, want.status);
				end
			end
			if (in_valid && !in_stall) begin
				predict_coeff(in_item, pred);
				if (row_typed) begin
					pred.read_value = row_value;
					pred.status = row_status;
				end
				coeff_queue.push_back(pred);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic send_row(input stim_row_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_item.action = r.action;
		in_item.pixel_index = r.pixel_index;
		in_item.pixel_value = r.pixel_value;
		row_typed = r.typed;
		row_value = r.typed_value;
		row_status = r.typed_status;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_plain(input logic [1:0] act, input logic [15:0] idx,
		input logic [31:0] val);
		send_row('{act, idx, val, 1'b0, 32'sd0, 1'b0});
	endtask

	// Drain outstanding results with the input side held quiet.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (coeff_queue.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			CFG_WIDTH: model_width = val;
			CFG_HEIGHT: model_height = val;
			CFG_LEVELS: model_levels = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			3: return $urandom;
			default: return 32'($signed($urandom_range(8388607)) - 4194304);
		endcase
	endfunction

	stim_row_t directed [0:19];
	logic [8:0] ph_width  [0:NPHASE-1] = '{9'd8, 9'd0, 9'd16, 9'd511, 9'd1, 9'd5, 9'd12, 9'd4};
	logic [8:0] ph_height [0:NPHASE-1] = '{9'd8, 9'd16, 9'd16, 9'd1, 9'd511, 9'd7, 9'd10, 9'd3};
	logic [8:0] ph_levels [0:NPHASE-1] = '{9'd1, 9'd3, 9'd8, 9'd1, 9'd15, 9'd0, 9'd2, 9'd2};

	initial begin
		int limit;
		int pick;
		cfg_write = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		row_typed = 1'b0;
		row_value = '0;
		row_status = 1'b0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		idle_cycles = 0;
		model_width = 9'd256;
		model_height = 9'd256;
		model_levels = 4'd1;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 4x3 image, two levels: odd height, extreme samples, every action
		for (int i = 0; i < 12; i++)
			directed[i] = '{ACT_WRITE, 16'(i), 32'sd0, 1'b1, 32'sd0, 1'b0};
		directed[0].pixel_value = 32'sh7fffffff;
		directed[1].pixel_value = 32'sh80000000;
		directed[2].pixel_value = 32'shffffffff;
		directed[3].pixel_value = 32'sh00010000;
		directed[5].pixel_value = 32'sh7fffffff;
		directed[6].pixel_value = 32'sh80000000;
		directed[8].pixel_value = 32'sh12345678;
		directed[11].pixel_value = 32'shfedcba98;
		directed[12] = '{ACT_WRITE, 16'd12, 32'sh55555555, 1'b1, 32'sd0, 1'b1};
		directed[13] = '{ACT_READ, 16'hffff, 32'sd0, 1'b1, 32'sd0, 1'b1};
		directed[14] = '{2'd3, 16'hffff, 32'shffffffff, 1'b1, 32'sd0, 1'b0};
		directed[15] = '{ACT_READ, 16'd1, 32'sd0, 1'b1, 32'sh80000000, 1'b0};
		directed[16] = '{ACT_START, 16'd0, 32'sd0, 1'b1, 32'sd0, 1'b0};
		directed[17] = '{ACT_READ, 16'd0, 32'sd0, 1'b0, 32'sd0, 1'b0};
		directed[18] = '{ACT_READ, 16'd5, 32'sd0, 1'b0, 32'sd0, 1'b0};
		directed[19] = '{ACT_READ, 16'd11, 32'sd0, 1'b0, 32'sd0, 1'b0};

		write_reg(CFG_WIDTH, 9'd4);
		write_reg(CFG_HEIGHT, 9'd3);
		write_reg(CFG_LEVELS, 9'd2);
		write_reg(2'd3, 9'h1ff);
		foreach (directed[i]) send_row(directed[i]);
		wait_drained();

		for (int p = 0; p < NPHASE; p++) begin
			write_reg(CFG_WIDTH, ph_width[p]);
			write_reg(CFG_HEIGHT, ph_height[p]);
			write_reg(CFG_LEVELS, ph_levels[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			limit = clamp_dim(model_width) * clamp_dim(model_height);
			// fill the whole image before any read or transform
			for (int i = 0; i < limit; i++) send_plain(ACT_WRITE, 16'(i), rand_sample());
			for (int n = 0; n < 26; n++) begin
				if (p == 1 && n == 25) wait_drained();
				pick = $urandom_range(99);
				if (pick < 45)
					send_plain(ACT_READ, 16'($urandom_range(limit - 1)), $urandom);
				else if (pick < 72)
					send_plain(ACT_WRITE, 16'($urandom_range(limit - 1)), rand_sample());
				else if (pick < 86)
					send_plain(pick[0] ? ACT_READ : ACT_WRITE,
						16'($urandom_range(65535, limit)), $urandom);
				else if (pick < 92)
					send_plain(2'd3, 16'($urandom), $urandom);
				else
					send_plain(ACT_START, 16'($urandom), $urandom);
			end
			send_plain(ACT_START, 16'd0, 32'd0);
			for (int n = 0; n < 12; n++)
				send_plain(ACT_READ, 16'($urandom_range(limit - 1)), 32'd0);
			wait_drained();
		end

		recv_stall_pct = 0;
		repeat (20) @(negedge clk);
		if (fail_count == 0 && coeff_queue.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
